/* rtl/tlgf_pkg.sv */
package tlgf_pkg;

  localparam int COORD_WIDTH = 16;

  localparam int GainFrac = 4;
  localparam int VelW     = COORD_WIDTH;
  localparam int DxW      = COORD_WIDTH + 2;
  localparam int GateW    = COORD_WIDTH + 4;
  localparam int MulW     = GateW + 1;
  localparam int ProdW    = 2 * MulW;
  localparam int AccW     = ProdW + 1;
  localparam int RadW     = 2 * COORD_WIDTH;
  localparam int RemW     = COORD_WIDTH + 3;
  localparam int SqCntW   = $clog2(COORD_WIDTH);
  localparam int WtW      = 9;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam logic [WtW-1:0] WeightOne = WtW'(256);
  localparam logic [7:0]     MissMax   = 8'hFF;

  typedef enum logic [2:0] {
    REG_MISS_TOL  = 3'd0,
    REG_BASE_GATE = 3'd1,
    REG_GATE_GAIN = 3'd2,
    REG_BLEND_WT  = 3'd3,
    REG_DECAY     = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VX2,
    S_VY2,
    S_SQI,
    S_SQRT,
    S_GAIN,
    S_GSUM,
    S_GSQ,
    S_DX,
    S_DY,
    S_CMP,
    S_BX1,
    S_BX2,
    S_BY1,
    S_BY2,
    S_BFIN,
    S_DECX,
    S_DECY,
    S_DFIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                   target_present;
    logic [COORD_WIDTH-1:0] target_x;
    logic [COORD_WIDTH-1:0] target_y;
  } tgt_beat_t;

  typedef struct packed {
    logic                          locked;
    logic                          accepted;
    logic [COORD_WIDTH-1:0]        track_x;
    logic [COORD_WIDTH-1:0]        track_y;
    logic signed [COORD_WIDTH-1:0] speed_x;
    logic signed [COORD_WIDTH-1:0] speed_y;
    logic [7:0]                    misses;
  } trk_beat_t;

  // divide by 256, round half away from zero, saturate to velocity range
  function automatic logic signed [VelW-1:0] round_q8(input logic signed [AccW-1:0] p);
    logic signed [AccW-1:0] s;
    logic signed [AccW-1:0] q;
    logic signed [AccW-1:0] vmax;
    logic signed [AccW-1:0] vmin;
    vmax = AccW'((64'sd1 <<< (VelW - 1)) - 64'sd1);
    vmin = -vmax - AccW'(1);
    s = p[AccW-1] ? (p + AccW'(127)) : (p + AccW'(128));
    q = s >>> 8;
    if (q > vmax) begin
      return vmax[VelW-1:0];
    end else if (q < vmin) begin
      return vmin[VelW-1:0];
    end
    return q[VelW-1:0];
  endfunction

endpackage

/* rtl/tlgf_ifs.sv */
interface tlgf_in_if import tlgf_pkg::*; ();
  logic      valid;
  logic      ready;
  tgt_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlgf_out_if import tlgf_pkg::*; ();
  logic      valid;
  logic      ready;
  trk_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/track_lock_gate_filter_unit.sv */
// A beat that acquires a track goes straight to its result, a missing target decays the
// velocity, and a locked target is gated, then blended (gate pass) or decayed (gate fail).
// This runs through the 16-step bit-pair square root and the single shared 21x21 multiplier.
// A new beat is taken only once the last one is done; it is taken while a result waits.
// Reset (async, active low): searching, track and velocity zero, registers at defaults.
module track_lock_gate_filter_unit import tlgf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tlgf_in_if.sink            tgt_i,
  tlgf_out_if.source         trk_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  localparam int W = COORD_WIDTH;

  state_e st_q, st_d;

  logic [7:0]       cfg_tol_q;
  logic [15:0]      cfg_base_q;
  logic [7:0]       cfg_gain_q;
  logic [WtW-1:0]   cfg_wt_q;
  logic [WtW-1:0]   cfg_decay_q;

  logic                  lock_q, lock_d;
  logic [W-1:0]          lastx_q, lastx_d, lasty_q, lasty_d;
  logic signed [W-1:0]   vx_q, vx_d, vy_q, vy_d;
  logic [7:0]            miss_q, miss_d;
  logic                  acc_flag_q, acc_flag_d;

  logic [W-1:0]          tx_q, tx_d, ty_q, ty_d;
  logic signed [AccW-1:0] acc_q, acc_d, g2_q, g2_d;
  logic signed [DxW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [RadW-1:0]       rad_q, rad_d;
  logic [RemW-1:0]       rem_q, rem_d;
  logic [W-1:0]          root_q, root_d;
  logic [SqCntW-1:0]     cnt_q, cnt_d;
  logic [GateW-1:0]      gate_q, gate_d;

  logic                  ovld_q, ovld_d;
  trk_beat_t             obeat_q, obeat_d;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [WtW-1:0]          wt_cl, wt_inv, dec_cl;
  logic signed [W:0]       nx, ny;
  logic [RemW-1:0]         rem_sh, trial;
  logic [7:0]              miss_inc;
  logic                    cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (cfg_reg_e'(paddr[4:2]))
      REG_MISS_TOL:  prdata = DataW'(cfg_tol_q);
      REG_BASE_GATE: prdata = DataW'(cfg_base_q);
      REG_GATE_GAIN: prdata = DataW'(cfg_gain_q);
      REG_BLEND_WT:  prdata = DataW'(cfg_wt_q);
      REG_DECAY:     prdata = DataW'(cfg_decay_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tol_q   <= 8'd15;
      cfg_base_q  <= 16'd1600;
      cfg_gain_q  <= 8'd32;
      cfg_wt_q    <= WtW'(51);
      cfg_decay_q <= WtW'(230);
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[4:2]))
        REG_MISS_TOL:  cfg_tol_q   <= pwdata[7:0];
        REG_BASE_GATE: cfg_base_q  <= pwdata[15:0];
        REG_GATE_GAIN: cfg_gain_q  <= pwdata[7:0];
        REG_BLEND_WT:  cfg_wt_q    <= pwdata[WtW-1:0];
        REG_DECAY:     cfg_decay_q <= pwdata[WtW-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign tgt_i.ready = (st_q == S_IDLE);
  assign trk_o.valid = ovld_q;
  assign trk_o.data  = obeat_q;

  // shared arithmetic
  assign wt_cl    = (cfg_wt_q > WeightOne) ? WeightOne : cfg_wt_q;
  assign wt_inv   = WeightOne - wt_cl;
  assign dec_cl   = (cfg_decay_q > WeightOne) ? WeightOne : cfg_decay_q;
  assign nx       = $signed({1'b0, tx_q}) - $signed({1'b0, lastx_q});
  assign ny       = $signed({1'b0, ty_q}) - $signed({1'b0, lasty_q});
  assign rem_sh   = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign miss_inc = (miss_q == MissMax) ? miss_q : miss_q + 8'd1;
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_VX2:  begin mul_a = MulW'(vx_q);    mul_b = MulW'(vx_q);    end
      S_VY2:  begin mul_a = MulW'(vy_q);    mul_b = MulW'(vy_q);    end
      S_GAIN: begin mul_a = MulW'(cfg_gain_q); mul_b = MulW'(root_q); end
      S_GSQ:  begin mul_a = MulW'(gate_q);  mul_b = MulW'(gate_q);  end
      S_DX:   begin mul_a = MulW'(dx_q);    mul_b = MulW'(dx_q);    end
      S_DY:   begin mul_a = MulW'(dy_q);    mul_b = MulW'(dy_q);    end
      S_BX1:  begin mul_a = MulW'(wt_cl);   mul_b = MulW'(nx);      end
      S_BX2:  begin mul_a = MulW'(wt_inv);  mul_b = MulW'(vx_q);    end
      S_BY1:  begin mul_a = MulW'(wt_cl);   mul_b = MulW'(ny);      end
      S_BY2:  begin mul_a = MulW'(wt_inv);  mul_b = MulW'(vy_q);    end
      S_DECX: begin mul_a = MulW'(dec_cl);  mul_b = MulW'(vx_q);    end
      S_DECY: begin mul_a = MulW'(dec_cl);  mul_b = MulW'(vy_q);    end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_d       = st_q;
    lock_d     = lock_q;
    lastx_d    = lastx_q;
    lasty_d    = lasty_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    miss_d     = miss_q;
    acc_flag_d = acc_flag_q;
    tx_d       = tx_q;
    ty_d       = ty_q;
    acc_d      = acc_q;
    g2_d       = g2_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    rad_d      = rad_q;
    rem_d      = rem_q;
    root_d     = root_q;
    cnt_d      = cnt_q;
    gate_d     = gate_q;
    ovld_d     = ovld_q & ~trk_o.ready;
    obeat_d    = obeat_q;

    case (st_q)
      S_IDLE: begin
        if (tgt_i.valid) begin
          tx_d       = tgt_i.data.target_x;
          ty_d       = tgt_i.data.target_y;
          acc_flag_d = 1'b0;
          if (!tgt_i.data.target_present) begin
            st_d = S_DECX;
          end else if (!lock_q) begin
            lock_d     = 1'b1;
            lastx_d    = tgt_i.data.target_x;
            lasty_d    = tgt_i.data.target_y;
            vx_d       = '0;
            vy_d       = '0;
            miss_d     = '0;
            acc_flag_d = 1'b1;
            st_d       = S_DONE;
          end else begin
            st_d = S_VX2;
          end
        end
      end
      S_VX2: begin
        acc_d = AccW'(mul_p);
        dx_d  = $signed({2'b00, tx_q}) - $signed({2'b00, lastx_q}) - DxW'(vx_q);
        st_d  = S_VY2;
      end
      S_VY2: begin
        acc_d = acc_q + AccW'(mul_p);
        dy_d  = $signed({2'b00, ty_q}) - $signed({2'b00, lasty_q}) - DxW'(vy_q);
        st_d  = S_SQI;
      end
      S_SQI: begin
        rad_d  = acc_q[RadW-1:0];
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
        st_d   = S_SQRT;
      end
      S_SQRT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q + SqCntW'(1);
        if (cnt_q == SqCntW'(W - 1)) begin
          st_d = S_GAIN;
        end
      end
      S_GAIN: begin
        acc_d = AccW'(mul_p);
        st_d  = S_GSUM;
      end
      S_GSUM: begin
        gate_d = GateW'(cfg_base_q) + acc_q[GateW+GainFrac-1:GainFrac];
        st_d   = S_GSQ;
      end
      S_GSQ: begin
        acc_d = AccW'(mul_p);
        st_d  = S_DX;
      end
      S_DX: begin
        g2_d  = acc_q;
        acc_d = AccW'(mul_p);
        st_d  = S_DY;
      end
      S_DY: begin
        acc_d = acc_q + AccW'(mul_p);
        st_d  = S_CMP;
      end
      S_CMP: begin
        st_d = (acc_q < g2_q) ? S_BX1 : S_DECX;
      end
      S_BX1: begin
        acc_d = AccW'(mul_p);
        st_d  = S_BX2;
      end
      S_BX2: begin
        acc_d = acc_q + AccW'(mul_p);
        st_d  = S_BY1;
      end
      S_BY1: begin
        vx_d  = round_q8(acc_q);
        acc_d = AccW'(mul_p);
        st_d  = S_BY2;
      end
      S_BY2: begin
        acc_d = acc_q + AccW'(mul_p);
        st_d  = S_BFIN;
      end
      S_BFIN: begin
        vy_d       = round_q8(acc_q);
        lastx_d    = tx_q;
        lasty_d    = ty_q;
        miss_d     = '0;
        acc_flag_d = 1'b1;
        st_d       = S_DONE;
      end
      S_DECX: begin
        acc_d = AccW'(mul_p);
        st_d  = S_DECY;
      end
      S_DECY: begin
        vx_d  = round_q8(acc_q);
        acc_d = AccW'(mul_p);
        st_d  = S_DFIN;
      end
      S_DFIN: begin
        vy_d   = round_q8(acc_q);
        miss_d = miss_inc;
        if (miss_inc > cfg_tol_q) begin
          lock_d = 1'b0;
          vx_d   = '0;
          vy_d   = '0;
        end
        st_d = S_DONE;
      end
      S_DONE: begin
        if (!ovld_q || trk_o.ready) begin
          ovld_d           = 1'b1;
          obeat_d.locked   = lock_q;
          obeat_d.accepted = acc_flag_q;
          obeat_d.track_x  = lastx_q;
          obeat_d.track_y  = lasty_q;
          obeat_d.speed_x  = vx_q;
          obeat_d.speed_y  = vy_q;
          obeat_d.misses   = miss_q;
          st_d             = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q     <= 1'b0;
      lastx_q    <= '0;
      lasty_q    <= '0;
      vx_q       <= '0;
      vy_q       <= '0;
      miss_q     <= '0;
      acc_flag_q <= 1'b0;
      ovld_q     <= 1'b0;
    end else begin
      lock_q     <= lock_d;
      lastx_q    <= lastx_d;
      lasty_q    <= lasty_d;
      vx_q       <= vx_d;
      vy_q       <= vy_d;
      miss_q     <= miss_d;
      acc_flag_q <= acc_flag_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q    <= tx_d;
    ty_q    <= ty_d;
    acc_q   <= acc_d;
    g2_q    <= g2_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    cnt_q   <= cnt_d;
    gate_q  <= gate_d;
    obeat_q <= obeat_d;
  end

endmodule
